// ===== hw/rtl/qrm_pkg.sv =====
// Package for the quaternion to rotation matrix block.
// Widths and constants of the datapath; no dependencies.
package qrm_pkg;

    localparam int DATA_WIDTH = 16;                  // Q3.13 input parts
    localparam int PROD_W     = 2 * DATA_WIDTH;      // one signed product
    localparam int NUM_W      = 2 * DATA_WIDTH + 3;  // signed numerator
    localparam int N_W        = 2 * DATA_WIDTH + 1;  // squared norm
    localparam int MAG_W      = 2 * DATA_WIDTH + 2;  // numerator magnitude
    localparam int FRAC_OUT   = 14;
    localparam int REM_W      = MAG_W + FRAC_OUT + 1;
    localparam int Q_W        = FRAC_OUT + 1;        // quotient up to 1.0
    localparam int OUT_W      = 16;
    localparam int N_ENT      = 9;
    localparam int DIV_STG    = Q_W;                 // one quotient bit per stage

    localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_OUT;

endpackage

// ===== hw/rtl/quaternion_to_rotation_matrix_top.sv =====
// Throughput one per cycle while the output is not stalled.
// Stages: products, numerators and norm, dividend, 15 restoring divide steps
// (one quotient bit each, nine lanes), sign / clamp / identity output register.
// The whole pipe advances together unless a held result is stalled; an empty
// output register lets the pipe advance, internal bubbles travel with the data.
// Reset (synchronous, active low) clears the valid bits only.
module quaternion_to_rotation_matrix_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [qrm_pkg::DATA_WIDTH-1:0] i_qw,
    input  logic signed [qrm_pkg::DATA_WIDTH-1:0] i_qx,
    input  logic signed [qrm_pkg::DATA_WIDTH-1:0] i_qy,
    input  logic signed [qrm_pkg::DATA_WIDTH-1:0] i_qz,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [qrm_pkg::OUT_W-1:0]      o_m00,
    output logic signed [qrm_pkg::OUT_W-1:0]      o_m01,
    output logic signed [qrm_pkg::OUT_W-1:0]      o_m02,
    output logic signed [qrm_pkg::OUT_W-1:0]      o_m10,
    output logic signed [qrm_pkg::OUT_W-1:0]      o_m11,
    output logic signed [qrm_pkg::OUT_W-1:0]      o_m12,
    output logic signed [qrm_pkg::OUT_W-1:0]      o_m20,
    output logic signed [qrm_pkg::OUT_W-1:0]      o_m21,
    output logic signed [qrm_pkg::OUT_W-1:0]      o_m22,
    output logic                                  o_zero_norm
);

    localparam int PW = qrm_pkg::PROD_W;
    localparam int NW = qrm_pkg::NUM_W;
    localparam int NE = qrm_pkg::N_ENT;
    localparam int DS = qrm_pkg::DIV_STG;
    localparam int RW = qrm_pkg::REM_W;
    localparam int QW = qrm_pkg::Q_W;
    localparam int OW = qrm_pkg::OUT_W;

    logic en;

    // stage 1: products
    logic              r_v1;
    logic signed [PW-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_zw, r_xz, r_yw, r_yz, r_xw;

    // stage 2: numerators
    logic                          r_v2;
    logic [qrm_pkg::N_W-1:0]       r_n2;
    logic                          r_z2;
    logic [qrm_pkg::MAG_W-1:0]     r_mag2 [NE];
    logic                          r_neg2 [NE];
    logic signed [NW-1:0]          n_num  [NE];
    logic signed [NW-1:0]          n_sum;

    // divider pipe, index 0 holds the dividend
    logic                          r_dv   [DS+1];
    logic                          r_dz   [DS+1];
    logic [qrm_pkg::N_W-1:0]       r_dn   [DS+1];
    logic                          r_dneg [DS+1][NE];
    logic [RW-1:0]                 r_drem [DS+1][NE];
    logic [QW-1:0]                 r_dq   [DS+1][NE];

    // output
    logic                          r_ov;
    logic                          r_oz;
    logic signed [OW-1:0]          r_om [NE];

    assign en      = !r_ov || !i_stall;
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ww <= i_qw * i_qw;
            r_xx <= i_qx * i_qx;
            r_yy <= i_qy * i_qy;
            r_zz <= i_qz * i_qz;
            r_xy <= i_qx * i_qy;
            r_zw <= i_qz * i_qw;
            r_xz <= i_qx * i_qz;
            r_yw <= i_qy * i_qw;
            r_yz <= i_qy * i_qz;
            r_xw <= i_qx * i_qw;
        end
    end

    always_comb begin
        n_sum    = NW'(r_ww) + NW'(r_xx) + NW'(r_yy) + NW'(r_zz);
        n_num[0] = NW'(r_ww) + NW'(r_xx) - NW'(r_yy) - NW'(r_zz);
        n_num[4] = NW'(r_ww) - NW'(r_xx) + NW'(r_yy) - NW'(r_zz);
        n_num[8] = NW'(r_ww) - NW'(r_xx) - NW'(r_yy) + NW'(r_zz);
        n_num[1] = (NW'(r_xy) + NW'(r_zw)) <<< 1;
        n_num[3] = (NW'(r_xy) - NW'(r_zw)) <<< 1;
        n_num[2] = (NW'(r_xz) - NW'(r_yw)) <<< 1;
        n_num[6] = (NW'(r_xz) + NW'(r_yw)) <<< 1;
        n_num[5] = (NW'(r_yz) + NW'(r_xw)) <<< 1;
        n_num[7] = (NW'(r_yz) - NW'(r_xw)) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n2 <= n_sum[qrm_pkg::N_W-1:0];
            r_z2 <= (n_sum == '0);
            for (int e = 0; e < NE; e++) begin
                r_neg2[e] <= n_num[e][NW-1];
                r_mag2[e] <= n_num[e][NW-1] ? qrm_pkg::MAG_W'(-n_num[e])
                                            : qrm_pkg::MAG_W'(n_num[e]);
            end
        end
    end

    // stage 3: dividend with half-divisor rounding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dn[0] <= r_n2;
            r_dz[0] <= r_z2;
            for (int e = 0; e < NE; e++) begin
                r_dneg[0][e] <= r_neg2[e];
                r_dq[0][e]   <= '0;
                r_drem[0][e] <= (RW'(r_mag2[e]) << qrm_pkg::FRAC_OUT)
                              + RW'(r_n2 >> 1);
            end
        end
    end

    // restoring divide, most significant quotient bit first
    for (genvar s = 0; s < DS; s++) begin : g_div
        localparam int K = DS - 1 - s;
        logic [RW-1:0] w_sub [NE];
        logic          w_ge  [NE];

        always_comb begin
            for (int e = 0; e < NE; e++) begin
                w_sub[e] = RW'(r_dn[s]) << K;
                w_ge[e]  = (r_drem[s][e] >= w_sub[e]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s+1] <= 1'b0;
            end else if (en) begin
                r_dv[s+1] <= r_dv[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dn[s+1] <= r_dn[s];
                r_dz[s+1] <= r_dz[s];
                for (int e = 0; e < NE; e++) begin
                    r_dneg[s+1][e] <= r_dneg[s][e];
                    r_drem[s+1][e] <= w_ge[e] ? r_drem[s][e] - w_sub[e] : r_drem[s][e];
                    r_dq[s+1][e]   <= {r_dq[s][e][QW-2:0], w_ge[e]};
                end
            end
        end
    end

    // sign, clamp to 1.0, identity on zero norm
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_dv[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [QW-1:0] q;
        if (en) begin
            r_oz <= r_dz[DS];
            for (int e = 0; e < NE; e++) begin
                q = (r_dq[DS][e] > qrm_pkg::ONE_Q) ? qrm_pkg::ONE_Q : r_dq[DS][e];
                if (r_dz[DS]) begin
                    r_om[e] <= (e % 4 == 0) ? OW'(qrm_pkg::ONE_Q) : '0;
                end else if (r_dneg[DS][e]) begin
                    r_om[e] <= -signed'(OW'(q));
                end else begin
                    r_om[e] <= OW'(q);
                end
            end
        end
    end

    assign o_valid     = r_ov;
    assign o_zero_norm = r_oz;
    assign o_m00 = r_om[0];
    assign o_m01 = r_om[1];
    assign o_m02 = r_om[2];
    assign o_m10 = r_om[3];
    assign o_m11 = r_om[4];
    assign o_m12 = r_om[5];
    assign o_m20 = r_om[6];
    assign o_m21 = r_om[7];
    assign o_m22 = r_om[8];

endmodule

// ===== sim/quaternion_to_rotation_matrix_top_tb.sv =====
// Testbench for quaternion_to_rotation_matrix_top: drives quaternions, predicts the
// normalized rotation matrix per transaction and checks every result in order.
// Depends on qrm_pkg and the RTL top level.
`timescale 1ns / 1ps

module quaternion_to_rotation_matrix_top_tb;

    localparam int LAT        = 19;
    localparam int CYCLE_MAX  = 400000;

    typedef logic signed [qrm_pkg::DATA_WIDTH-1:0] t_part;
    typedef logic signed [qrm_pkg::OUT_W-1:0]      t_entry;

    typedef struct {
        t_entry m [qrm_pkg::N_ENT];
        logic   zero_norm;
    } t_matrix;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_stall;
    t_part i_qw = '0, i_qx = '0, i_qy = '0, i_qz = '0;
    logic  o_valid;
    logic  i_stall = 1'b0;
    t_entry o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22;
    logic  o_zero_norm;

    t_matrix pending_mats [$];
    int      errors = 0;
    int      cycles = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    quaternion_to_rotation_matrix_top u_dut (.*);

    always #2 i_clk = ~i_clk;

    // numerator / norm in Q2.14, round half away from zero, clamp to 1.0
    function automatic longint ratio_q14(longint num, longint nrm);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = ((mag << qrm_pkg::FRAC_OUT) + (nrm >> 1)) / nrm;
        if (q > (1 << qrm_pkg::FRAC_OUT)) q = 1 << qrm_pkg::FRAC_OUT;
        return (num < 0) ? -q : q;
    endfunction

    function automatic t_matrix predict_matrix(t_part qw, t_part qx, t_part qy, t_part qz);
        t_matrix r;
        longint w, x, y, z, ww, xx, yy, zz, nrm;
        w = qw; x = qx; y = qy; z = qz;
        ww = w * w; xx = x * x; yy = y * y; zz = z * z;
        nrm = ww + xx + yy + zz;
        if (nrm == 0) begin
            foreach (r.m[i]) r.m[i] = (i % 4 == 0) ? t_entry'(1 << qrm_pkg::FRAC_OUT) : '0;
            r.zero_norm = 1'b1;
            return r;
        end
        r.m[0] = t_entry'(ratio_q14(ww + xx - yy - zz, nrm));
        r.m[4] = t_entry'(ratio_q14(ww - xx + yy - zz, nrm));
        r.m[8] = t_entry'(ratio_q14(ww - xx - yy + zz, nrm));
        r.m[1] = t_entry'(ratio_q14(2 * (x * y + z * w), nrm));
        r.m[3] = t_entry'(ratio_q14(2 * (x * y - z * w), nrm));
        r.m[2] = t_entry'(ratio_q14(2 * (x * z - y * w), nrm));
        r.m[6] = t_entry'(ratio_q14(2 * (x * z + y * w), nrm));
        r.m[5] = t_entry'(ratio_q14(2 * (y * z + x * w), nrm));
        r.m[7] = t_entry'(ratio_q14(2 * (y * z - x * w), nrm));
        r.zero_norm = 1'b0;
        return r;
    endfunction

    // one transaction; valid stays high across back-to-back sends
    task automatic send_quat(t_part qw, t_part qx, t_part qy, t_part qz);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_qw <= qw; i_qx <= qx; i_qy <= qy; i_qz <= qz;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_mats.push_back(predict_matrix(qw, qx, qy, qz));
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n)
            i_stall <= (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_matrix want;
        t_entry  got [qrm_pkg::N_ENT];
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22};
            if (pending_mats.size() == 0) begin
                $display("%0t: unexpected result", $time);
                errors++;
            end else begin
                want = pending_mats.pop_front();
                foreach (got[i]) begin
                    if (got[i] !== want.m[i]) begin
                        $display("%0t: m%0d%0d expected %0d actual %0d", $time,
                                 i / 3, i % 3, want.m[i], got[i]);
                        errors++;
                    end
                end
                if (o_zero_norm !== want.zero_norm) begin
                    $display("%0t: zero_norm expected %0b actual %0b", $time,
                             want.zero_norm, o_zero_norm);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_extremes();
        t_part vals [5] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, 16'shffff};
        send_quat('0, '0, '0, '0);                   // zero norm -> identity
        send_quat(16'sh2000, '0, '0, '0);            // unit identity
        send_quat('0, 16'sh2000, '0, '0);
        send_quat('0, '0, 16'sh2000, '0);
        send_quat('0, '0, '0, 16'sh2000);
        send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_quat(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        send_quat('0, '0, '0, 16'sh0001);            // tiny norm
        foreach (vals[i])
            send_quat(vals[i], vals[(i + 1) % 5], vals[(i + 2) % 5], vals[(i + 3) % 5]);
        send_quat(16'sh0001, 16'sh0001, '0, '0);     // norm of two
        send_quat(16'sh0003, 16'sh0001, 16'sh0001, 16'sh0001);
        end_burst();
    endtask

    task automatic test_random(int count);
        t_part p [4];
        int    sel;
        repeat (count) begin
            sel = $urandom_range(9);
            foreach (p[k]) begin
                case (sel)
                    0: p[k] = t_part'($urandom_range(3)) - 1;          // tiny magnitudes
                    1: p[k] = ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
                    2: p[k] = ($urandom_range(3) == 0) ? t_part'($urandom) : '0;
                    default: p[k] = t_part'($urandom);
                endcase
            end
            send_quat(p[0], p[1], p[2], p[3]);
        end
        end_burst();
    endtask

    task automatic drain();
        int waited = 0;
        while (pending_mats.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        send_idle_pct = 32; recv_stall_pct = 74;
        test_random(450);
        send_idle_pct = 74; recv_stall_pct = 32;
        test_random(450);
        send_idle_pct = 0; recv_stall_pct = 0;
        test_random(450);
        drain();

        if (errors == 0 && pending_mats.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
